// ----- sv/toeq_pkg.sv -----
// Package for the time-ordered event queue.
// Holds the event entry type, cell control type and command/status codes.
// No dependencies.
`timescale 1ns / 1ps

package toeq_pkg;

   localparam int TIME_W  = 20;
   localparam int KIND_W  = 4;
   localparam int WORD_W  = 16;
   localparam int OCC_W   = 5;
   localparam int STAT_W  = 2;

   typedef struct packed {
      logic [TIME_W-1:0] time_stamp;
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] second;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctl_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_RESERVED  = 2'd3
   } status_type;

endpackage

// ----- sv/time_ordered_event_queue.sv -----
// Top level of the time-ordered event queue: chain of toeq_cell, count and result register.
// Depends on toeq_pkg and toeq_cell.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | command, time, kind, two data words
//   rsp     | out       | rsp_valid/rsp_ready   | status, removed event, empty, occupancy
//
// One transaction per cycle unless rsp_ready stalls: all cells compare with the new time
// in parallel and shift in one step; the result appears in the cycle after acceptance.
// req_ready is high while the result register is empty or being taken.
// Reset clears the count and the result valid; cell contents are not reset.
`timescale 1ns / 1ps

module time_ordered_event_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [19:0] req_event_time,
   input  logic [3:0]  req_event_kind,
   input  logic [15:0] req_first_datum,
   input  logic [15:0] req_second_datum,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [19:0] rsp_out_time,
   output logic [3:0]  rsp_out_kind,
   output logic [15:0] rsp_out_first,
   output logic [15:0] rsp_out_second,
   output logic        rsp_is_empty,
   output logic [4:0]  rsp_occupancy
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   toeq_pkg::status_type status_ff, status_in;
   toeq_pkg::entry_type  gone_ff, gone_in;
   logic                 empty_ff, empty_in;
   logic [4:0]           occ_ff, occ_in;

   toeq_pkg::entry_type  new_entry;
   toeq_pkg::entry_type  cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_gt;
   logic [QUEUE_DEPTH-1:0] cell_occ;
   toeq_pkg::cell_ctl_type ctl;

   logic accept, full, empty, do_ins, do_rem;
   logic [CNT_W+4:0] count_wide;

   assign new_entry.time_stamp = req_event_time;
   assign new_entry.kind       = req_event_kind;
   assign new_entry.first      = req_first_datum;
   assign new_entry.second     = req_second_datum;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_ins    = accept && (req_command == toeq_pkg::CMD_INSERT) && !full;
   assign do_rem    = accept && (req_command == toeq_pkg::CMD_REMOVE) && !empty;
   assign ctl.ins   = do_ins;
   assign ctl.rem   = do_rem;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         assign cell_occ[i] = (CNT_W'(i) < count_ff);
         toeq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (cell_occ[i]),
            .new_entry  (new_entry),
            .prev_entry ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
            .prev_gt    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i-1]),
            .next_entry (cell_entry[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .entry      (cell_entry[i]),
            .gt         (cell_gt[i])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      gone_in      = gone_ff;
      empty_in     = empty_ff;
      occ_in       = occ_ff;
      count_wide   = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         gone_in      = '0;
         status_in    = toeq_pkg::STATUS_OK;
         if (req_command == toeq_pkg::CMD_INSERT) begin
            if (full) begin
               status_in = toeq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (empty) begin
               status_in = toeq_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               gone_in  = cell_entry[0];
            end
         end
         count_wide = {5'b0, count_in};
         empty_in   = (count_in == '0);
         occ_in     = count_wide[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      gone_ff   <= gone_in;
      empty_ff  <= empty_in;
      occ_ff    <= occ_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_time   = gone_ff.time_stamp;
   assign rsp_out_kind   = gone_ff.kind;
   assign rsp_out_first  = gone_ff.first;
   assign rsp_out_second = gone_ff.second;
   assign rsp_is_empty   = empty_ff;
   assign rsp_occupancy  = occ_ff;

endmodule

// ----- sv/toeq_cell.sv -----
// One cell of the sorted event chain: holds a single entry.
// Shifts towards the tail on insert, towards the head on remove.
// Depends on toeq_pkg.
`timescale 1ns / 1ps

module toeq_cell (
   input  logic                  clock,
   input  toeq_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  toeq_pkg::entry_type   new_entry,
   input  toeq_pkg::entry_type   prev_entry,
   input  logic                  prev_gt,
   input  toeq_pkg::entry_type   next_entry,
   output toeq_pkg::entry_type   entry,
   output logic                  gt
);

   toeq_pkg::entry_type entry_ff;

   // later than the new event: it must move one place back
   assign gt    = occupied && (entry_ff.time_stamp > new_entry.time_stamp);
   assign entry = entry_ff;

   always_ff @(posedge clock) begin
      if (ctl.ins) begin
         if (prev_gt) begin
            entry_ff <= prev_entry;
         end else if (gt || !occupied) begin
            entry_ff <= new_entry;
         end
      end else if (ctl.rem) begin
         entry_ff <= next_entry;
      end
   end

endmodule

// ----- test/tb_time_ordered_event_queue.sv -----
// Testbench for time_ordered_event_queue: directed and random insert/remove traffic with
// random idling on both channels, every result checked against a local schedule model.
// Depends on toeq_pkg and the time_ordered_event_queue RTL.
`timescale 1ns / 1ps

module tb_time_ordered_event_queue;

   localparam int SLOTS       = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_OPS  = 1350;

   typedef struct packed {
      logic                  pause;
      toeq_pkg::command_type cmd;
      toeq_pkg::entry_type   ev;
   } event_request_type;

   typedef struct packed {
      toeq_pkg::status_type           status;
      toeq_pkg::entry_type            removed;
      logic                           is_empty;
      logic [toeq_pkg::OCC_W-1:0]     occupancy;
   } queue_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [19:0] req_event_time = '0;
   logic [3:0]  req_event_kind = '0;
   logic [15:0] req_first_datum = '0;
   logic [15:0] req_second_datum = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [19:0] rsp_out_time;
   logic [3:0]  rsp_out_kind;
   logic [15:0] rsp_out_first;
   logic [15:0] rsp_out_second;
   logic        rsp_is_empty;
   logic [4:0]  rsp_occupancy;

   event_request_type   pending_requests[$];
   queue_result_type    awaited_results[$];
   toeq_pkg::entry_type schedule[$];
   queue_result_type    oldest;
   int                  issued_count = 0;
   int                  retired_count = 0;
   int                  failures = 0;
   int                  cycle_count = 0;
   int                  ready_cycles = 0;
   int                  hold_left = 0;

   time_ordered_event_queue #(.QUEUE_DEPTH(SLOTS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_event_time(req_event_time), .req_event_kind(req_event_kind),
      .req_first_datum(req_first_datum), .req_second_datum(req_second_datum),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_time(rsp_out_time), .rsp_out_kind(rsp_out_kind),
      .rsp_out_first(rsp_out_first), .rsp_out_second(rsp_out_second),
      .rsp_is_empty(rsp_is_empty), .rsp_occupancy(rsp_occupancy)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Applies one transaction to the local schedule and returns the result it must produce.
   function automatic queue_result_type apply_to_schedule(toeq_pkg::command_type cmd,
                                                          toeq_pkg::entry_type ev);
      queue_result_type r;
      int pos;
      r = '0;
      r.status = toeq_pkg::STATUS_OK;
      if (cmd == toeq_pkg::CMD_INSERT) begin
         if (schedule.size() >= SLOTS) begin
            r.status = toeq_pkg::STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < schedule.size() && schedule[pos].time_stamp <= ev.time_stamp)
               pos++;
            schedule.insert(pos, ev);
         end
      end else if (schedule.size() == 0) begin
         r.status = toeq_pkg::STATUS_EMPTY;
      end else begin
         r.removed = schedule.pop_front();
      end
      r.is_empty  = (schedule.size() == 0);
      r.occupancy = toeq_pkg::OCC_W'(schedule.size());
      return r;
   endfunction

   task automatic queue_event(toeq_pkg::command_type cmd, logic [19:0] t, logic [3:0] k,
                              logic [15:0] a, logic [15:0] b);
      event_request_type rq;
      rq.pause = 1'b0;
      rq.cmd   = cmd;
      rq.ev    = '{time_stamp: t, kind: k, first: a, second: b};
      pending_requests.push_back(rq);
   endtask

   task automatic queue_pause();
      event_request_type rq;
      rq = '0;
      rq.pause = 1'b1;
      pending_requests.push_back(rq);
   endtask

   function automatic logic [19:0] pick_time();
      case ($urandom_range(3))
         0: return 20'($urandom_range(7));
         1: return 20'($urandom);
         2: return $urandom_range(1) ? 20'hFFFFF : 20'h0;
         default: return 20'hFFFF8 | 20'($urandom_range(7));
      endcase
   endfunction

   task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   // Sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(apply_to_schedule(
               toeq_pkg::command_type'(req_command),
               '{time_stamp: req_event_time, kind: req_event_kind,
                 first: req_first_datum, second: req_second_datum}));
            issued_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && pending_requests[0].pause
                && issued_count == retired_count)
               void'(pending_requests.pop_front());
            if (pending_requests.size() > 0 && !pending_requests[0].pause
                && !((issued_count < 500 || issued_count >= 700)
                     && $urandom_range(99) < 15)) begin
               req_command      <= pending_requests[0].cmd;
               req_event_time   <= pending_requests[0].ev.time_stamp;
               req_event_kind   <= pending_requests[0].ev.kind;
               req_first_datum  <= pending_requests[0].ev.first;
               req_second_datum <= pending_requests[0].ev.second;
               req_valid        <= 1'b1;
               void'(pending_requests.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver ready, with two long hold-offs that back the queue up into the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         ready_cycles <= 0;
         hold_left    <= 0;
      end else begin
         ready_cycles <= ready_cycles + 1;
         if (ready_cycles == 300 || ready_cycles == 1200) begin
            hold_left <= 120;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (ready_cycles >= 800 && ready_cycles < 1000)
                         || ($urandom_range(99) >= 15);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $error("result transaction with none outstanding");
            failures++;
         end else begin
            oldest = awaited_results.pop_front();
            check_field("status", 20'(oldest.status), 20'(rsp_status));
            check_field("out_time", oldest.removed.time_stamp, rsp_out_time);
            check_field("out_kind", 20'(oldest.removed.kind), 20'(rsp_out_kind));
            check_field("out_first", 20'(oldest.removed.first), 20'(rsp_out_first));
            check_field("out_second", 20'(oldest.removed.second), 20'(rsp_out_second));
            check_field("is_empty", 20'(oldest.is_empty), 20'(rsp_is_empty));
            check_field("occupancy", 20'(oldest.occupancy), 20'(rsp_occupancy));
         end
         retired_count <= retired_count + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int insert_pct;
      // remove from empty, fill with extremes and equal times, refuse when full
      queue_event(toeq_pkg::CMD_REMOVE, 20'h0, 4'h0, 16'h0, 16'h0);
      queue_event(toeq_pkg::CMD_INSERT, 20'd5, 4'h1, 16'h1111, 16'h2222);
      queue_event(toeq_pkg::CMD_INSERT, 20'd5, 4'h2, 16'h3333, 16'h4444);
      queue_event(toeq_pkg::CMD_INSERT, 20'h0, 4'h0, 16'h0000, 16'h0000);
      queue_event(toeq_pkg::CMD_INSERT, 20'hFFFFF, 4'hF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 12; i++)
         queue_event(toeq_pkg::CMD_INSERT, 20'($urandom_range(9)), 4'($urandom),
                     16'($urandom), 16'($urandom));
      queue_event(toeq_pkg::CMD_INSERT, 20'h1, 4'hA, 16'hAAAA, 16'h5555);
      for (int i = 0; i < 4; i++)
         queue_event(toeq_pkg::CMD_REMOVE, 20'($urandom), 4'($urandom),
                     16'($urandom), 16'($urandom));
      queue_pause();
      // random part: runs biased to fill, drain or balance
      insert_pct = 50;
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i % 40 == 0)
            case ($urandom_range(2))
               0: insert_pct = 80;
               1: insert_pct = 20;
               default: insert_pct = 50;
            endcase
         if (i == RANDOM_OPS / 2)
            queue_pause();
         queue_event(($urandom_range(99) < insert_pct) ? toeq_pkg::CMD_INSERT
                                                       : toeq_pkg::CMD_REMOVE,
                     pick_time(), 4'($urandom), 16'($urandom), 16'($urandom));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || retired_count != issued_count);
      repeat (4) @(negedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d results never arrived", awaited_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/toeq_pkg.sv
sv/toeq_cell.sv
sv/time_ordered_event_queue.sv
test/tb_time_ordered_event_queue.sv
